FILE: rtl/core/irfb_pkg.sv
// Package: shared types, constants and the frame byte selector for the IGMP report builder.
`timescale 1ns / 1ps
`default_nettype none
package irfb_pkg;

    // Frame geometry
    localparam int unsigned FRAME_LEN = 60;
    localparam int unsigned IDX_W     = 6;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

    // Field widths
    localparam int unsigned IP_W  = 32;
    localparam int unsigned MAC_W = 48;
    localparam int unsigned CK_W  = 16;

    // Fixed header bytes
    localparam logic [7:0] MCAST_MAC0  = 8'h01;
    localparam logic [7:0] MCAST_MAC1  = 8'h00;
    localparam logic [7:0] MCAST_MAC2  = 8'h5e;
    localparam logic [7:0] GRP_MAC_MSK = 8'h7F;
    localparam logic [7:0] ETYPE_HI    = 8'h08;
    localparam logic [7:0] ETYPE_LO    = 8'h00;
    localparam logic [7:0] IP_VER_IHL  = 8'h45;
    localparam logic [7:0] IP_TOS      = 8'hC0;
    localparam logic [7:0] IP_LEN_HI   = 8'h00;
    localparam logic [7:0] IP_LEN_LO   = 8'h1C;
    localparam logic [7:0] IP_ID_HI    = 8'h00;
    localparam logic [7:0] IP_ID_LO    = 8'h01;
    localparam logic [7:0] IP_FRAG_HI  = 8'h00;
    localparam logic [7:0] IP_FRAG_LO  = 8'h00;
    localparam logic [7:0] IP_TTL      = 8'h01;
    localparam logic [7:0] IP_PROTO    = 8'h02;
    localparam logic [7:0] IGMP_TYPE   = 8'h16;
    localparam logic [7:0] IGMP_MRT    = 8'h64;
    localparam logic [CK_W-1:0] CK_MASK = 16'hffff;

    // Sum of the constant 16-bit words of the IPv4 header and of the IGMP message
    localparam logic [CK_W-1:0] IP_CONST_SUM =
        {IP_VER_IHL, IP_TOS} + {IP_LEN_HI, IP_LEN_LO} + {IP_ID_HI, IP_ID_LO}
        + {IP_FRAG_HI, IP_FRAG_LO} + {IP_TTL, IP_PROTO};
    localparam logic [CK_W-1:0] IGMP_CONST_SUM = {IGMP_TYPE, IGMP_MRT};

    // Everything one frame needs, held while it is sent
    typedef struct packed {
        logic [IP_W-1:0]  source_ip;
        logic [MAC_W-1:0] source_mac;
        logic [IP_W-1:0]  group;
        logic [CK_W-1:0]  ip_ck;
        logic [CK_W-1:0]  igmp_ck;
    } frame_t;

    // Pick one byte of the frame by its position
    function automatic logic [7:0] frame_byte_at(logic [IDX_W-1:0] idx, frame_t f);
        logic [7:0] b;
        b = 8'h00;
        unique case (idx)
            6'd0:  b = MCAST_MAC0;
            6'd1:  b = MCAST_MAC1;
            6'd2:  b = MCAST_MAC2;
            6'd3:  b = f.group[23:16] & GRP_MAC_MSK;
            6'd4:  b = f.group[15:8];
            6'd5:  b = f.group[7:0];
            6'd6:  b = f.source_mac[47:40];
            6'd7:  b = f.source_mac[39:32];
            6'd8:  b = f.source_mac[31:24];
            6'd9:  b = f.source_mac[23:16];
            6'd10: b = f.source_mac[15:8];
            6'd11: b = f.source_mac[7:0];
            6'd12: b = ETYPE_HI;
            6'd13: b = ETYPE_LO;
            6'd14: b = IP_VER_IHL;
            6'd15: b = IP_TOS;
            6'd16: b = IP_LEN_HI;
            6'd17: b = IP_LEN_LO;
            6'd18: b = IP_ID_HI;
            6'd19: b = IP_ID_LO;
            6'd20: b = IP_FRAG_HI;
            6'd21: b = IP_FRAG_LO;
            6'd22: b = IP_TTL;
            6'd23: b = IP_PROTO;
            6'd24: b = f.ip_ck[15:8];
            6'd25: b = f.ip_ck[7:0];
            6'd26: b = f.source_ip[31:24];
            6'd27: b = f.source_ip[23:16];
            6'd28: b = f.source_ip[15:8];
            6'd29: b = f.source_ip[7:0];
            6'd30: b = f.group[31:24];
            6'd31: b = f.group[23:16];
            6'd32: b = f.group[15:8];
            6'd33: b = f.group[7:0];
            6'd34: b = IGMP_TYPE;
            6'd35: b = IGMP_MRT;
            6'd36: b = f.igmp_ck[15:8];
            6'd37: b = f.igmp_ck[7:0];
            6'd38: b = f.group[31:24];
            6'd39: b = f.group[23:16];
            6'd40: b = f.group[15:8];
            6'd41: b = f.group[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/igmp_report_frame_builder_unit.sv
// Top level: IGMPv2 membership report frame builder with group register and input register.
`timescale 1ns / 1ps
`default_nettype none
// Each request transfer (source IP, source MAC) produces one 60-byte Ethernet frame
// carrying an IGMPv2 membership report for the group in the group register, sent as
// 60 byte transfers, one per cycle while the sink is ready, with tlast on byte 59.
// While a frame is sent by the byte serializer, the next request is held in the
// input register and its checksums are computed there, so consecutive frames
// follow with no gap. The group is sampled when a request is taken; write the
// register only while no frame is pending.
module igmp_report_frame_builder_unit
    import irfb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Group address register
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    // Request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // [31:0] source_ip, [79:32] source_mac
    // Frame byte stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] frame_byte, [13:8] byte_index, zero fill
    output logic             m_tlast    // last_byte
);

    localparam logic [IP_W-1:0] GROUP_RESET = 32'hE0000001;

    logic [IP_W-1:0]  group_reg;
    logic             in_valid_reg, in_valid_next;
    logic [IP_W-1:0]  in_ip_reg;
    logic [MAC_W-1:0] in_mac_reg;
    logic [IP_W-1:0]  in_grp_reg;
    logic [CK_W-1:0]  ip_ck;
    logic [CK_W-1:0]  igmp_ck;
    frame_t           frame_in;
    logic             take;
    logic             s_fire;
    logic [7:0]       out_byte;
    logic [IDX_W-1:0] out_idx;

    // Group register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg <= GROUP_RESET;
        end
        else if (cfg_we)
        begin
            group_reg <= cfg_wdata;
        end
    end

    // Input register: free when empty or handed to the serializer
    assign s_tready = !in_valid_reg || take;
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b0;
        end
        if (s_fire)
        begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_ip_reg  <= s_tdata[IP_W-1:0];
            in_mac_reg <= s_tdata[IP_W+MAC_W-1:IP_W];
            in_grp_reg <= group_reg;
        end
    end

    // Checksums of the held request
    irfb_csum u_csum
    (
        .source_ip (in_ip_reg),
        .group     (in_grp_reg),
        .ip_ck     (ip_ck),
        .igmp_ck   (igmp_ck)
    );

    assign frame_in.source_ip  = in_ip_reg;
    assign frame_in.source_mac = in_mac_reg;
    assign frame_in.group      = in_grp_reg;
    assign frame_in.ip_ck      = ip_ck;
    assign frame_in.igmp_ck    = igmp_ck;

    // Byte serializer and output register
    irfb_serializer u_ser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (in_valid_reg),
        .load_frame (frame_in),
        .load_take  (take),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (out_byte),
        .out_idx    (out_idx),
        .out_last   (m_tlast)
    );

    assign m_tdata = {2'b00, out_idx, out_byte};

    // tlast marks exactly the final byte position
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[13:8] == LAST_IDX)))
        else $error("tlast does not match byte index");

    // Within a frame the next byte follows at once with the next index
    a_next_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && (m_tdata[13:8] == $past(m_tdata[13:8]) + 6'd1)))
        else $error("frame byte sequence broken");

    // A held request is only replaced after it was handed on
    a_hold_req: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !take) |=> (in_valid_reg && $stable(in_ip_reg)
            && $stable(in_mac_reg) && $stable(in_grp_reg)))
        else $error("held request lost");

endmodule
`default_nettype wire

FILE: rtl/core/irfb_csum.sv
// Checksum logic: IPv4 header and IGMP ones'-complement checksums from the held request.
`timescale 1ns / 1ps
`default_nettype none
module irfb_csum
    import irfb_pkg::*;
(
    input  wire logic [IP_W-1:0] source_ip,
    input  wire logic [IP_W-1:0] group,
    output logic      [CK_W-1:0] ip_ck,
    output logic      [CK_W-1:0] igmp_ck
);

    // Five 16-bit words fit in 19 bits
    localparam int unsigned SUM_W = CK_W + 3;

    logic [SUM_W-1:0] ip_sum;
    logic [SUM_W-1:0] igmp_sum;
    logic [CK_W:0]    ip_f1;
    logic [CK_W:0]    igmp_f1;
    logic [CK_W-1:0]  ip_f2;
    logic [CK_W-1:0]  igmp_f2;

    // Add the variable words to the constant part of each sum
    assign ip_sum = SUM_W'(IP_CONST_SUM) + SUM_W'(source_ip[31:16])
                  + SUM_W'(source_ip[15:0]) + SUM_W'(group[31:16])
                  + SUM_W'(group[15:0]);
    assign igmp_sum = SUM_W'(IGMP_CONST_SUM) + SUM_W'(group[31:16])
                    + SUM_W'(group[15:0]);

    // Fold the carries twice; after the second fold none is left
    assign ip_f1   = (CK_W+1)'(ip_sum[CK_W-1:0]) + (CK_W+1)'(ip_sum[SUM_W-1:CK_W]);
    assign igmp_f1 = (CK_W+1)'(igmp_sum[CK_W-1:0]) + (CK_W+1)'(igmp_sum[SUM_W-1:CK_W]);
    assign ip_f2   = ip_f1[CK_W-1:0] + CK_W'(ip_f1[CK_W]);
    assign igmp_f2 = igmp_f1[CK_W-1:0] + CK_W'(igmp_f1[CK_W]);

    // Complement
    assign ip_ck   = ~ip_f2 & CK_MASK;
    assign igmp_ck = ~igmp_f2 & CK_MASK;

endmodule
`default_nettype wire

FILE: rtl/core/irfb_serializer.sv
// Frame serializer: holds one frame, steps a byte counter and drives the output register.
`timescale 1ns / 1ps
`default_nettype none
module irfb_serializer
    import irfb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load_valid,
    input  wire frame_t           load_frame,
    output logic                  load_take,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [7:0]            out_byte,
    output logic [IDX_W-1:0]      out_idx,
    output logic                  out_last
);

    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    frame_t           frame_reg, frame_next;
    logic             oval_reg, oval_next;
    logic [7:0]       obyte_reg, obyte_next;
    logic [IDX_W-1:0] oidx_reg, oidx_next;
    logic             olast_reg, olast_next;
    logic             advance;
    logic             frame_done;

    // Output register moves when empty or taken
    assign advance    = !oval_reg || out_ready;
    assign frame_done = !busy_reg || (cnt_reg == LAST_IDX);
    assign load_take  = advance && frame_done && load_valid;

    // Emit the current byte, then load the next frame behind the last byte
    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        frame_next = frame_reg;
        oval_next  = oval_reg;
        obyte_next = obyte_reg;
        oidx_next  = oidx_reg;
        olast_next = olast_reg;
        if (advance)
        begin
            oval_next = busy_reg;
            if (busy_reg)
            begin
                obyte_next = frame_byte_at(cnt_reg, frame_reg);
                oidx_next  = cnt_reg;
                olast_next = (cnt_reg == LAST_IDX);
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    busy_next = 1'b0;
                end
            end
        end
        if (load_take)
        begin
            frame_next = load_frame;
            busy_next  = 1'b1;
            cnt_next   = '0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            oval_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            oval_reg <= oval_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
        obyte_reg <= obyte_next;
        oidx_reg  <= oidx_next;
        olast_reg <= olast_next;
    end

    assign out_valid = oval_reg;
    assign out_byte  = obyte_reg;
    assign out_idx   = oidx_reg;
    assign out_last  = olast_reg;

endmodule
`default_nettype wire
